@@ src/tqus_pkg.sv @@
package tqus_pkg;

  // Fixed widths of the request and result fields
  localparam int unsigned FUNC_BITS   = 2;
  localparam int unsigned FIELD_BITS  = 16;
  localparam int unsigned STATUS_BITS = 3;
  localparam int unsigned COUNT_BITS  = 7;

  typedef enum logic [FUNC_BITS-1:0] {
    CMD_ADD  = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_UNDO = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 3'd0,
    ST_QEMPTY  = 3'd1,
    ST_HEMPTY  = 3'd2,
    ST_BADTIME = 3'd3,
    ST_QFULL   = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_FIN  = 1'b1
  } state_t;

endpackage

@@ src/tqus_if.sv @@
interface tqus_in_if;
  logic                                valid;
  logic                                ready;
  logic [tqus_pkg::FUNC_BITS-1:0]      func;
  logic [tqus_pkg::FIELD_BITS-1:0]     task_tag;
  logic [tqus_pkg::FIELD_BITS-1:0]     task_time;

  modport source (output valid, func, task_tag, task_time, input ready);
  modport sink   (input valid, func, task_tag, task_time, output ready);
endinterface

interface tqus_out_if;
  logic                                valid;
  logic                                ready;
  logic [tqus_pkg::STATUS_BITS-1:0]    result_status;
  logic [tqus_pkg::FIELD_BITS-1:0]     out_tag;
  logic [tqus_pkg::FIELD_BITS-1:0]     out_time;
  logic [tqus_pkg::COUNT_BITS-1:0]     queue_count;
  logic [tqus_pkg::COUNT_BITS-1:0]     history_count;

  modport source (output valid, result_status, out_tag, out_time, queue_count,
                  history_count, input ready);
  modport sink   (input valid, result_status, out_tag, out_time, queue_count,
                  history_count, output ready);
endinterface

@@ src/tqus_ram.sv @@
module tqus_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/task_queue_with_undo_stack_core.sv @@
// Channel   Dir   Payload                                                   Handshake
// in_ch     in    func, task_tag, task_time                                 valid/ready
// out_ch    out   result_status, out_tag, out_time, queue_count,            valid/ready
//                 history_count
//
// Add, rejected commands and the unused code load the result register directly; run and
// undo pass through S_FIN first, as the queue and history memories have a registered read.
// One request is in flight at a time; a new one is taken once the result
// register is free or being drained in the same cycle.
// rst_n is synchronous and active low; it empties queue and history at once.
// A stalled result holds in the output register and blocks further requests.
module task_queue_with_undo_stack_core #(
  parameter int unsigned QUEUE_DEPTH   = 64,
  parameter int unsigned HISTORY_DEPTH = 64,
  parameter int unsigned TAG_BITS      = 16,
  parameter int unsigned TIME_BITS     = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  tqus_in_if.sink    in_ch,
  tqus_out_if.source out_ch
);

  localparam int unsigned QIW = $clog2(QUEUE_DEPTH);
  localparam int unsigned HIW = $clog2(HISTORY_DEPTH);
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned HCW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned EW  = TAG_BITS + TIME_BITS;

  tqus_pkg::state_t state_r, state_nxt;
  logic             pend_run_r, pend_run_nxt;
  logic [QIW-1:0]   head_r, head_nxt;
  logic [QCW-1:0]   qfill_r, qfill_nxt;
  logic [HIW-1:0]   htop_r, htop_nxt;
  logic [HCW-1:0]   hfill_r, hfill_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic [tqus_pkg::STATUS_BITS-1:0]    status_r, status_nxt;
  logic [tqus_pkg::FIELD_BITS-1:0]     tag_r, tag_nxt;
  logic [tqus_pkg::FIELD_BITS-1:0]     time_r, time_nxt;
  logic [tqus_pkg::COUNT_BITS-1:0]     qcnt_r, qcnt_nxt;
  logic [tqus_pkg::COUNT_BITS-1:0]     hcnt_r, hcnt_nxt;

  logic           q_we, h_we;
  logic [QIW-1:0] q_waddr;
  logic [HIW-1:0] h_waddr;
  logic [EW-1:0]  q_wdata, h_wdata, q_rdata, h_rdata;

  logic           in_fire, out_fire, load_imm;
  logic [31:0]    tag_ext, time_ext, fwd_tag_ext, fwd_time_ext, qc_ext, hc_ext;
  logic [TAG_BITS-1:0]  tag_st;
  logic [TIME_BITS-1:0] time_st;
  logic [EW-1:0]  fwd_entry;
  logic [QIW:0]   tail_sum;
  logic [QIW-1:0] tail, head_inc, head_dec;
  logic [HIW-1:0] htop_inc, htop_dec;
  logic           q_full;
  tqus_pkg::status_t imm_status;

  tqus_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  tqus_ram #(.WIDTH(EW), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (htop_r),
    .rdata (h_rdata)
  );

  // Handshakes
  assign in_ch.ready = (state_r == tqus_pkg::S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;

  // Mask request fields to the stored widths
  assign tag_ext  = 32'(in_ch.task_tag);
  assign time_ext = 32'(in_ch.task_time);
  assign tag_st   = tag_ext[TAG_BITS-1:0];
  assign time_st  = time_ext[TIME_BITS-1:0];

  // Ring pointer arithmetic
  assign tail_sum = (QIW+1)'(head_r) + (QIW+1)'(qfill_r);
  assign tail     = (tail_sum >= (QIW+1)'(QUEUE_DEPTH)) ?
                    QIW'(tail_sum - (QIW+1)'(QUEUE_DEPTH)) : tail_sum[QIW-1:0];
  assign head_inc = (head_r == QIW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? QIW'(QUEUE_DEPTH - 1) : head_r - 1'b1;
  assign htop_inc = (htop_r == HIW'(HISTORY_DEPTH - 1)) ? '0 : htop_r + 1'b1;
  assign htop_dec = (htop_r == '0) ? HIW'(HISTORY_DEPTH - 1) : htop_r - 1'b1;
  assign q_full   = (qfill_r == QCW'(QUEUE_DEPTH));

  // Entry moved in the S_FIN step of run or undo
  assign fwd_entry    = pend_run_r ? q_rdata : h_rdata;
  assign fwd_tag_ext  = 32'(fwd_entry[EW-1:TIME_BITS]);
  assign fwd_time_ext = 32'(fwd_entry[TIME_BITS-1:0]);

  assign qc_ext = 32'(qfill_nxt);
  assign hc_ext = 32'(hfill_nxt);

  // Next state, memory writes and result
  always_comb begin
    state_nxt     = state_r;
    pend_run_nxt  = pend_run_r;
    head_nxt      = head_r;
    qfill_nxt     = qfill_r;
    htop_nxt      = htop_r;
    hfill_nxt     = hfill_r;
    out_valid_nxt = out_valid_r && !out_fire;
    status_nxt    = status_r;
    tag_nxt       = tag_r;
    time_nxt      = time_r;
    qcnt_nxt      = qcnt_r;
    hcnt_nxt      = hcnt_r;
    q_we          = 1'b0;
    q_waddr       = tail;
    q_wdata       = {tag_st, time_st};
    h_we          = 1'b0;
    h_waddr       = htop_r;
    h_wdata       = q_rdata;
    load_imm      = 1'b0;
    imm_status    = tqus_pkg::ST_OK;

    case (state_r)
      tqus_pkg::S_IDLE: begin
        if (in_fire) begin
          load_imm = 1'b1;
          case (in_ch.func)
            tqus_pkg::CMD_ADD: begin
              if (time_st == '0) begin
                imm_status = tqus_pkg::ST_BADTIME;
              end else if (q_full) begin
                imm_status = tqus_pkg::ST_QFULL;
              end else begin
                q_we      = 1'b1;
                qfill_nxt = qfill_r + 1'b1;
              end
            end
            tqus_pkg::CMD_RUN: begin
              if (qfill_r == '0) begin
                imm_status = tqus_pkg::ST_QEMPTY;
              end else begin
                // Read front now, push to history next cycle
                load_imm     = 1'b0;
                pend_run_nxt = 1'b1;
                head_nxt     = head_inc;
                qfill_nxt    = qfill_r - 1'b1;
                htop_nxt     = htop_inc;
                if (hfill_r != HCW'(HISTORY_DEPTH)) begin
                  hfill_nxt = hfill_r + 1'b1;
                end
                state_nxt = tqus_pkg::S_FIN;
              end
            end
            tqus_pkg::CMD_UNDO: begin
              if (hfill_r == '0) begin
                imm_status = tqus_pkg::ST_HEMPTY;
              end else if (q_full) begin
                imm_status = tqus_pkg::ST_QFULL;
              end else begin
                // Read newest history now, restore to front next cycle
                load_imm     = 1'b0;
                pend_run_nxt = 1'b0;
                htop_nxt     = htop_dec;
                hfill_nxt    = hfill_r - 1'b1;
                head_nxt     = head_dec;
                qfill_nxt    = qfill_r + 1'b1;
                state_nxt    = tqus_pkg::S_FIN;
              end
            end
            default: begin
              imm_status = tqus_pkg::ST_OK;
            end
          endcase
        end
      end
      tqus_pkg::S_FIN: begin
        if (pend_run_r) begin
          h_we    = 1'b1;
          h_waddr = htop_r;
          h_wdata = q_rdata;
        end else begin
          q_we    = 1'b1;
          q_waddr = head_r;
          q_wdata = h_rdata;
        end
        out_valid_nxt = 1'b1;
        status_nxt    = tqus_pkg::ST_OK;
        tag_nxt       = fwd_tag_ext[tqus_pkg::FIELD_BITS-1:0];
        time_nxt      = fwd_time_ext[tqus_pkg::FIELD_BITS-1:0];
        qcnt_nxt      = qc_ext[tqus_pkg::COUNT_BITS-1:0];
        hcnt_nxt      = hc_ext[tqus_pkg::COUNT_BITS-1:0];
        state_nxt     = tqus_pkg::S_IDLE;
      end
      default: begin
        state_nxt = tqus_pkg::S_IDLE;
      end
    endcase

    // Result for add, rejected and unused commands, loaded straight from the request
    if (load_imm) begin
      out_valid_nxt = 1'b1;
      status_nxt    = imm_status;
      tag_nxt       = '0;
      time_nxt      = '0;
      qcnt_nxt      = qc_ext[tqus_pkg::COUNT_BITS-1:0];
      hcnt_nxt      = hc_ext[tqus_pkg::COUNT_BITS-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tqus_pkg::S_IDLE;
      head_r      <= '0;
      qfill_r     <= '0;
      htop_r      <= '0;
      hfill_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      qfill_r     <= qfill_nxt;
      htop_r      <= htop_nxt;
      hfill_r     <= hfill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_run_r <= pend_run_nxt;
    status_r   <= status_nxt;
    tag_r      <= tag_nxt;
    time_r     <= time_nxt;
    qcnt_r     <= qcnt_nxt;
    hcnt_r     <= hcnt_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_status = status_r;
  assign out_ch.out_tag       = tag_r;
  assign out_ch.out_time      = time_r;
  assign out_ch.queue_count   = qcnt_r;
  assign out_ch.history_count = hcnt_r;

  // Fill counts never pass the memory depths
  assert property (@(posedge clk) disable iff (!rst_n) qfill_r <= QCW'(QUEUE_DEPTH))
    else $error("queue fill exceeds depth");
  assert property (@(posedge clk) disable iff (!rst_n) hfill_r <= HCW'(HISTORY_DEPTH))
    else $error("history fill exceeds depth");

  // No new request while a run or undo completes
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == tqus_pkg::S_FIN) |-> !in_ch.ready)
    else $error("request taken during completion cycle");

  // Completion cycle always presents a result
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == tqus_pkg::S_FIN) |=> out_valid_r)
    else $error("completion without result");

  // Only one memory is written in a cycle
  assert property (@(posedge clk) disable iff (!rst_n) !(q_we && h_we))
    else $error("both memories written together");

endmodule

@@ sim/task_queue_checker.sv @@
`timescale 1ns / 1ps

module task_queue_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [tqus_pkg::FUNC_BITS-1:0]   in_func,
  input  logic [tqus_pkg::FIELD_BITS-1:0]  in_task_tag,
  input  logic [tqus_pkg::FIELD_BITS-1:0]  in_task_time,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [tqus_pkg::STATUS_BITS-1:0] out_result_status,
  input  logic [tqus_pkg::FIELD_BITS-1:0]  out_tag,
  input  logic [tqus_pkg::FIELD_BITS-1:0]  out_time,
  input  logic [tqus_pkg::COUNT_BITS-1:0]  out_queue_count,
  input  logic [tqus_pkg::COUNT_BITS-1:0]  out_history_count,
  output int                               errors,
  output int                               pending,
  output int                               results_checked,
  output int                               full_rejects,
  output int                               history_overwrites,
  output int                               peak_queue
);

  localparam int QUEUE_SLOTS   = 64;
  localparam int HISTORY_SLOTS = 64;

  typedef struct packed {
    logic [tqus_pkg::FIELD_BITS-1:0] tag;
    logic [tqus_pkg::FIELD_BITS-1:0] dur;
  } task_entry_t;

  typedef struct packed {
    tqus_pkg::status_t               status;
    logic [tqus_pkg::FIELD_BITS-1:0] tag;
    logic [tqus_pkg::FIELD_BITS-1:0] dur;
    logic [tqus_pkg::COUNT_BITS-1:0] qcount;
    logic [tqus_pkg::COUNT_BITS-1:0] hcount;
  } outcome_t;

  // Shadow copy of the task deque and the history ring
  task_entry_t queue_slots [QUEUE_SLOTS];
  logic [5:0]  queue_front;
  int          queue_len;
  task_entry_t history_slots [HISTORY_SLOTS];
  logic [5:0]  history_newest;
  int          history_len;

  outcome_t expected_outcomes [$];
  int error_total     = 0;
  int checked_total   = 0;
  int full_total      = 0;
  int overwrite_total = 0;
  int peak_total      = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    error_total++;
    if (error_total <= 40)
      $display("[%0t] %s mismatch at result %0d: got 0x%0h, expected 0x%0h",
               $time, what, checked_total, got, want);
  endtask

  // Apply one command to the shadow state and return the result it yields
  function automatic outcome_t apply_command(
      input logic [tqus_pkg::FUNC_BITS-1:0]  func,
      input logic [tqus_pkg::FIELD_BITS-1:0] tag,
      input logic [tqus_pkg::FIELD_BITS-1:0] dur);
    outcome_t    res;
    task_entry_t entry;
    logic [5:0]  slot;
    res.status = tqus_pkg::ST_OK;
    res.tag    = '0;
    res.dur    = '0;
    case (func)
      tqus_pkg::CMD_ADD: begin
        if (dur == '0) begin
          res.status = tqus_pkg::ST_BADTIME;
        end else if (queue_len >= QUEUE_SLOTS) begin
          res.status = tqus_pkg::ST_QFULL;
          full_total++;
        end else begin
          entry.tag = tag;
          entry.dur = dur;
          slot = queue_front + 6'(queue_len);
          queue_slots[slot] = entry;
          queue_len++;
        end
      end
      tqus_pkg::CMD_RUN: begin
        if (queue_len == 0) begin
          res.status = tqus_pkg::ST_QEMPTY;
        end else begin
          entry = queue_slots[queue_front];
          queue_front = queue_front + 6'd1;
          queue_len--;
          history_newest = history_newest + 6'd1;
          history_slots[history_newest] = entry;
          // A full history loses its oldest entry
          if (history_len < HISTORY_SLOTS) history_len++;
          else overwrite_total++;
          res.tag = entry.tag;
          res.dur = entry.dur;
        end
      end
      tqus_pkg::CMD_UNDO: begin
        if (history_len == 0) begin
          res.status = tqus_pkg::ST_HEMPTY;
        end else if (queue_len >= QUEUE_SLOTS) begin
          res.status = tqus_pkg::ST_QFULL;
          full_total++;
        end else begin
          entry = history_slots[history_newest];
          history_newest = history_newest - 6'd1;
          history_len--;
          queue_front = queue_front - 6'd1;
          queue_slots[queue_front] = entry;
          queue_len++;
          res.tag = entry.tag;
          res.dur = entry.dur;
        end
      end
      default: ;
    endcase
    if (queue_len > peak_total) peak_total = queue_len;
    res.qcount = tqus_pkg::COUNT_BITS'(queue_len);
    res.hcount = tqus_pkg::COUNT_BITS'(history_len);
    return res;
  endfunction

  // Retire results first, then predict the newly accepted request
  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      queue_front    = '0;
      queue_len      = 0;
      history_newest = '0;
      history_len    = 0;
      expected_outcomes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch("unexpected result, status", int'(out_result_status), 0);
        end else begin
          want = expected_outcomes.pop_front();
          if (out_result_status !== want.status)
            report_mismatch("status", int'(out_result_status), int'(want.status));
          if (out_tag !== want.tag)
            report_mismatch("tag", int'(out_tag), int'(want.tag));
          if (out_time !== want.dur)
            report_mismatch("time", int'(out_time), int'(want.dur));
          if (out_queue_count !== want.qcount)
            report_mismatch("queue count", int'(out_queue_count), int'(want.qcount));
          if (out_history_count !== want.hcount)
            report_mismatch("history count", int'(out_history_count), int'(want.hcount));
        end
        checked_total++;
      end
      if (in_valid && in_ready)
        expected_outcomes.push_back(apply_command(in_func, in_task_tag, in_task_time));
    end
    errors             <= error_total;
    pending            <= expected_outcomes.size();
    results_checked    <= checked_total;
    full_rejects       <= full_total;
    history_overwrites <= overwrite_total;
    peak_queue         <= peak_total;
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam logic [tqus_pkg::FUNC_BITS-1:0] CMD_SPARE = 2'd3;
  localparam int RANDOM_REQUESTS = 1950;
  localparam int CYCLE_LIMIT     = 500000;
  localparam logic [tqus_pkg::FIELD_BITS-1:0] FIELD_MAX = '1;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_UNDO, MIX_EVEN} mix_t;

  logic clk;
  logic rst_n;
  int   cycles = 0;
  int   burst_left = 0;
  int   requests_sent = 0;

  int errors;
  int pending;
  int results_checked;
  int full_rejects;
  int history_overwrites;
  int peak_queue;

  tqus_in_if  in_ch ();
  tqus_out_if out_ch ();

  task_queue_with_undo_stack_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  task_queue_checker queue_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .in_func            (in_ch.func),
    .in_task_tag        (in_ch.task_tag),
    .in_task_time       (in_ch.task_time),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_result_status  (out_ch.result_status),
    .out_tag            (out_ch.out_tag),
    .out_time           (out_ch.out_time),
    .out_queue_count    (out_ch.queue_count),
    .out_history_count  (out_ch.history_count),
    .errors             (errors),
    .pending            (pending),
    .results_checked    (results_checked),
    .full_rejects       (full_rejects),
    .history_overwrites (history_overwrites),
    .peak_queue         (peak_queue)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: rotate between free flow, light and heavy stalls, and a fixed cadence
  always @(posedge clk) begin
    case ((cycles / 300) % 4)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
      2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= ((cycles % 9) < 5);
    endcase
  end

  // Hold one request until accepted, then maybe idle between bursts
  task automatic send_request(input logic [tqus_pkg::FUNC_BITS-1:0] func,
                              input logic [tqus_pkg::FIELD_BITS-1:0] tag,
                              input logic [tqus_pkg::FIELD_BITS-1:0] dur);
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.func      <= func;
    in_ch.task_tag  <= tag;
    in_ch.task_time <= dur;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    requests_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off until every outstanding result has drained
  task automatic drain_results;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One random command, weighted by the current traffic mix
  task automatic random_request(input mix_t mix, output bit counted);
    int roll;
    int add_w;
    int run_w;
    logic [tqus_pkg::FIELD_BITS-1:0] tag;
    logic [tqus_pkg::FIELD_BITS-1:0] dur;
    case (mix)
      MIX_FILL:  begin add_w = 80; run_w = 8;  end
      MIX_DRAIN: begin add_w = 12; run_w = 80; end
      MIX_UNDO:  begin add_w = 20; run_w = 25; end
      default:   begin add_w = 40; run_w = 30; end
    endcase
    roll = $urandom_range(0, 99);
    tag = tqus_pkg::FIELD_BITS'($urandom);
    case ($urandom_range(0, 9))
      0:       dur = 16'd1;
      1:       dur = FIELD_MAX;
      default: dur = tqus_pkg::FIELD_BITS'($urandom_range(1, 65535));
    endcase
    counted = 1'b1;
    if (roll < add_w)
      send_request(tqus_pkg::CMD_ADD, tag, dur);
    else if (roll < add_w + run_w)
      send_request(tqus_pkg::CMD_RUN, tag, dur);
    else if (roll < 96)
      send_request(tqus_pkg::CMD_UNDO, tag, dur);
    else if (roll < 99)
      send_request(tqus_pkg::CMD_ADD, tag, '0);
    else begin
      send_request(CMD_SPARE, tag, dur);
      counted = 1'b0;
    end
  endtask

  initial begin
    int   counted_total;
    int   phase_len;
    bit   counted;
    mix_t mix;

    in_ch.valid     <= 1'b0;
    in_ch.func      <= tqus_pkg::CMD_ADD;
    in_ch.task_tag  <= '0;
    in_ch.task_time <= '0;
    rst_n           <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty cases, bad time, spare code, field extremes, undo round trips
    send_request(tqus_pkg::CMD_RUN,  16'h0000, 16'h0000);
    send_request(tqus_pkg::CMD_UNDO, 16'h0000, 16'h0000);
    send_request(tqus_pkg::CMD_ADD,  FIELD_MAX, 16'h0000);
    send_request(CMD_SPARE,          FIELD_MAX, FIELD_MAX);
    send_request(tqus_pkg::CMD_ADD,  FIELD_MAX, FIELD_MAX);
    send_request(tqus_pkg::CMD_ADD,  16'h0000, 16'h0001);
    send_request(tqus_pkg::CMD_ADD,  16'hA5A5, 16'h5A5A);
    send_request(tqus_pkg::CMD_ADD,  16'h5A5A, 16'h8000);
    send_request(tqus_pkg::CMD_RUN,  16'h0000, 16'h0000);
    send_request(tqus_pkg::CMD_UNDO, 16'h0000, 16'h0000);
    repeat (5) send_request(tqus_pkg::CMD_RUN, FIELD_MAX, FIELD_MAX);
    repeat (3) send_request(tqus_pkg::CMD_UNDO, 16'h0000, 16'h0000);
    send_request(tqus_pkg::CMD_ADD,  16'h0001, FIELD_MAX);
    send_request(tqus_pkg::CMD_UNDO, 16'h0000, 16'h0000);
    send_request(tqus_pkg::CMD_RUN,  16'h0000, 16'h0000);
    drain_results();

    // Random: a fill-weighted phase first, then a drain-weighted phase, then mixed phases
    counted_total = 0;
    mix = MIX_FILL;
    while (counted_total < RANDOM_REQUESTS) begin
      phase_len = $urandom_range(40, 140);
      repeat (phase_len) begin
        random_request(mix, counted);
        if (counted) counted_total++;
      end
      if ($urandom_range(0, 3) == 0) drain_results();
      if (mix == MIX_FILL && counted_total < 200) mix = MIX_DRAIN;
      else mix = mix_t'($urandom_range(0, 3));
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("Sent %0d requests in random bursts against a stalling result side",
             requests_sent);
    $display("Checked %0d results: %0d full-queue rejects, %0d history overwrites, %s %0d",
             results_checked, full_rejects, history_overwrites, "peak depth", peak_queue);
    if (errors == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
